// ===== rtl/lbp_pkg.sv =====
// Shared constants for the 3x3 local binary pattern block.
// Used by lbp_code_window_top; no dependencies.
`default_nettype none

package lbp_pkg;

    localparam int MAX_WIDTH_DEF = 1024;   // default line store depth
    localparam int PIX_W         = 8;      // gray pixel width
    localparam int CODE_W        = 8;      // pattern code width
    localparam int FW_W          = 11;     // frame_width register width
    localparam int FH_W          = 16;     // frame_height register width
    localparam int CFG_DATA_W    = 16;     // widest register
    localparam int CFG_IDX_W     = 1;      // two registers

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam int FW_RESET = 640;
    localparam int FH_RESET = 480;
    localparam int MIN_DIM  = 3;

endpackage

`default_nettype wire

// ===== rtl/lbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/lbp_code_window_top.sv =====
// Top level: 3x3 local binary pattern over a raster pixel stream.
// Depends on lbp_pkg and lbp_ram (two line store instances).
//
//  channel   | dir | tdata                 | tuser | tlast
//  ----------+-----+-----------------------+-------+------------------
//  s_axis    | in  | [7:0] pixel           |  -    |  -
//  m_axis    | out | [7:0] pattern_code    |  -    | frame_last
//  cfg       | in  | i_cfg_idx selects frame_width / frame_height
//
// One pixel per clock sustained while the output is not stalled. A pixel
// is read from both line stores the cycle it is taken; once the pixel
// stage moves on, its column is formed, the code is computed into the
// output register and the line stores are written back. Reset clears
// counters and the window; line stores are not cleared (rows 0 and 1
// fill them first). A stalled output holds pixel stage and RAM read data.
`default_nettype none

module lbp_code_window_top
    import lbp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // pixel stream in
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel
    // code stream out
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [CODE_W-1:0]     m_axis_tdata,   // [7:0] pattern_code
    output logic                       m_axis_tlast,   // frame_last
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WIDE_W = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
    localparam int RST_W  = (FW_RESET > MAX_WIDTH) ? MAX_WIDTH : FW_RESET;

    // frame bounds, kept as last column / last row
    logic [COL_W-1:0] r_last_col, n_last_col;
    logic [FH_W-1:0]  r_last_row, n_last_row;
    logic             cfg_hit;

    // input position counters
    logic [COL_W-1:0] r_col;
    logic [FH_W-1:0]  r_row;

    // pixel stage (RAM read data aligned with it)
    logic             r_p_valid;
    logic [PIX_W-1:0] r_p_pix;
    logic [COL_W-1:0] r_p_col;
    logic             r_p_emit;
    logic             r_p_last;

    // window: previous two columns, {top, middle, bottom}
    logic [3*PIX_W-1:0] r_win_prev;
    logic [3*PIX_W-1:0] r_win_old;
    logic [3*PIX_W-1:0] col_new;

    // output register
    logic              r_o_valid;
    logic [CODE_W-1:0] r_o_code;
    logic              r_o_last;

    logic [PIX_W-1:0] rd_upper, rd_middle;
    logic             in_acc, p_adv;
    logic [WIDE_W-1:0] cfg_w;
    logic [FH_W-1:0]   cfg_h;
    logic [CODE_W-1:0] code;
    logic [PIX_W-1:0]  ctr;

    assign p_adv         = r_p_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_p_valid || p_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ---------------- configuration ----------------
    always_comb begin
        cfg_hit    = 1'b0;
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        cfg_w      = WIDE_W'(i_cfg_data[FW_W-1:0]);
        cfg_h      = i_cfg_data[FH_W-1:0];
        if (cfg_w < WIDE_W'(MIN_DIM)) begin
            cfg_w = WIDE_W'(MIN_DIM);
        end else if (cfg_w > WIDE_W'(MAX_WIDTH)) begin
            cfg_w = WIDE_W'(MAX_WIDTH);
        end
        if (cfg_h < FH_W'(MIN_DIM)) begin
            cfg_h = FH_W'(MIN_DIM);
        end
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH: begin
                    cfg_hit    = 1'b1;
                    n_last_col = COL_W'(cfg_w - WIDE_W'(1));
                end
                REG_FRAME_HEIGHT: begin
                    cfg_hit    = 1'b1;
                    n_last_row = cfg_h - FH_W'(1);
                end
                default: cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= COL_W'(RST_W - 1);
            r_last_row <= FH_W'(FH_RESET - 1);
        end else begin
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
        end
    end

    // ---------------- position counters + pixel stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_p_valid <= 1'b0;
        end else begin
            if (cfg_hit) begin
                // restart the frame
                r_col <= '0;
                r_row <= '0;
            end else if (in_acc) begin
                if (r_col == r_last_col) begin
                    r_col <= '0;
                    r_row <= (r_row == r_last_row) ? '0 : r_row + FH_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (in_acc) begin
                r_p_valid <= 1'b1;
            end else if (p_adv) begin
                r_p_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p_pix  <= s_axis_tdata;
            r_p_col  <= r_col;
            r_p_emit <= (r_row >= FH_W'(2)) && (r_col >= COL_W'(2));
            r_p_last <= (r_row == r_last_row) && (r_col == r_last_col);
        end
    end

    // ---------------- line stores ----------------
    // read on accept, write back when the pixel stage moves on;
    // the two addresses never coincide since width >= 3
    lbp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (p_adv),
        .i_waddr (r_p_col),
        .i_wdata (rd_middle),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (rd_upper)
    );

    lbp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (p_adv),
        .i_waddr (r_p_col),
        .i_wdata (r_p_pix),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (rd_middle)
    );

    // ---------------- code ----------------
    assign col_new = {rd_upper, rd_middle, r_p_pix};
    assign ctr     = r_win_prev[2*PIX_W-1:PIX_W];

    always_comb begin
        code[7] = r_win_old[3*PIX_W-1:2*PIX_W]  > ctr;   // top-left
        code[6] = r_win_prev[3*PIX_W-1:2*PIX_W] > ctr;   // top
        code[5] = col_new[3*PIX_W-1:2*PIX_W]    > ctr;   // top-right
        code[4] = col_new[2*PIX_W-1:PIX_W]      > ctr;   // right
        code[3] = col_new[PIX_W-1:0]            > ctr;   // bottom-right
        code[2] = r_win_prev[PIX_W-1:0]         > ctr;   // bottom
        code[1] = r_win_old[PIX_W-1:0]          > ctr;   // bottom-left
        code[0] = r_win_old[2*PIX_W-1:PIX_W]    > ctr;   // left
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_prev <= '0;
            r_win_old  <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (p_adv) begin
                r_win_old  <= r_win_prev;
                r_win_prev <= col_new;
            end
            if (p_adv && r_p_emit) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_adv && r_p_emit) begin
            r_o_code <= code;
            r_o_last <= r_p_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_code;
    assign m_axis_tlast  = r_o_last;

endmodule

`default_nettype wire
